/* rtl/core/kms_pkg.sv */
// shared types and constants for the k-way merge selector
package kms_pkg;

  localparam int VAL_W       = 32;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int MAX_STREAMS = 16;

  // candidate handed from cell to cell during a scan
  typedef struct packed {
    logic                    tok;
    logic                    found;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
  } cand_t;

  // refill broadcast to all cells
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    has;
  } wr_t;

  // head clear after a stream wins
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } clr_t;

endpackage

/* rtl/core/kway_merge_select.sv */
// top level of the k-way merge selector: control, output register, cell chain
//
//   channel  direction  handshake                      payload
//   in       input      in_valid / in_stall            stream_index, head_value, has_value
//   out      output     out_valid / out_stall          merged_value, refill_stream, finished
//   cfg      input      psel / penable / pwrite / pready  paddr, pwdata, prdata
//
// an item that leaves some stream in use unresolved goes from check back to idle
// an item that yields a finished word is loaded from check once the output is free; one
// that yields a merged word passes check, scan and emit, the scan set by the
// candidate walking the cell chain one cell per clock
// rst_n is synchronous; it clears all flags and sets stream_count to 1
// a result waits in the output register while the next item is accepted;
// the following result holds in the control until that register drains
module kway_merge_select #(
  parameter int STREAMS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kms_pkg::IDX_W-1:0]        in_stream_index,
  input  logic signed [kms_pkg::VAL_W-1:0] in_head_value,
  input  logic                             in_has_value,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [kms_pkg::VAL_W-1:0] out_merged_value,
  output logic [kms_pkg::IDX_W-1:0]        out_refill_stream,
  output logic                             out_finished,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import kms_pkg::*;

  // only the first sixteen streams are addressable
  localparam int CELLS = (STREAMS < MAX_STREAMS) ? STREAMS : MAX_STREAMS;
  localparam logic [CNT_W-1:0] LIM = CNT_W'(CELLS);

  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an input word
  localparam logic [1:0] S_CHECK = 2'd1;  // readiness check on updated flags
  localparam logic [1:0] S_SCAN  = 2'd2;  // candidate walking the chain
  localparam logic [1:0] S_EMIT  = 2'd3;  // winner held until output frees

  localparam logic REG_COUNT = 1'b0;      // stream_count register index

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        n_eff;
  logic [MAX_STREAMS-1:0]  used;
  logic [MAX_STREAMS-1:0]  present_vec;
  logic [MAX_STREAMS-1:0]  done_vec;
  logic                    all_ready;
  logic                    all_done;
  logic                    slot_free;
  logic                    in_acc;
  logic                    cfg_wr;

  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_fin_r, out_fin_nxt;
  logic                    load_res;
  logic                    load_fin;

  wr_t                     wr;
  clr_t                    clr_sel;
  logic                    clr_all;
  cand_t                   chain [0:CELLS];
  logic [CELLS-1:0]        tok_vec;

  // config register, apb write in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign count_nxt = (cfg_wr && (paddr[2] == REG_COUNT)) ? pwdata[CNT_W-1:0] : count_r;
  assign prdata = (paddr[2] == REG_COUNT) ? {{(32-CNT_W){1'b0}}, count_r} : 32'd0;

  // effective stream count clamped to 1..CELLS
  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_r > LIM) begin
      n_eff = LIM;
    end else begin
      n_eff = count_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      used[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign all_ready = ((present_vec | done_vec) & used) == used;
  assign all_done  = (done_vec & used) == used;
  assign slot_free = !out_valid_r || !out_stall;

  // input accepted only while idle; indexes beyond the count change no stream flags
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign wr.en  = in_acc && ({1'b0, in_stream_index} < n_eff);
  assign wr.idx = in_stream_index;
  assign wr.val = in_head_value;
  assign wr.has = in_has_value;

  // scan starts at the head of the chain
  assign chain[0].tok   = (state_r == S_CHECK) && all_ready && !all_done;
  assign chain[0].found = 1'b0;
  assign chain[0].val   = '0;
  assign chain[0].idx   = '0;

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      kms_cell #(
        .IDX (g)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .clr_sel  (clr_sel),
        .clr_all  (clr_all),
        .used     (used[g]),
        .cand_in  (chain[g]),
        .cand_out (chain[g+1]),
        .present  (present_vec[g]),
        .done     (done_vec[g])
      );
      assign tok_vec[g] = chain[g+1].tok;
    end
    for (g = CELLS; g < MAX_STREAMS; g++) begin : g_pad
      assign present_vec[g] = 1'b0;
      assign done_vec[g]    = 1'b0;
    end
  endgenerate

  // control sequencer
  always_comb begin
    state_nxt    = state_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    load_res     = 1'b0;
    load_fin     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!all_ready) begin
          state_nxt = S_IDLE;
        end else if (all_done) begin
          // every stream in use exhausted: finished word once output is free
          if (slot_free) begin
            load_fin  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[CELLS].tok) begin
          best_val_nxt = chain[CELLS].val;
          best_idx_nxt = chain[CELLS].idx;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_res  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign clr_all     = load_fin;
  assign clr_sel.en  = load_res;
  assign clr_sel.idx = best_idx_r;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_fin_nxt   = out_fin_r;
    if (load_res || load_fin) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = load_res ? best_val_r : '0;
      out_idx_nxt   = load_res ? best_idx_r : '0;
      out_fin_nxt   = load_fin;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_merged_value  = out_val_r;
  assign out_refill_stream = out_idx_r;
  assign out_finished      = out_fin_r;

  // at most one candidate is in flight along the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  // a finished word leaves every stream flag cleared
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_fin |=> (present_vec == '0) && (done_vec == '0))
    else $error("stream flags not cleared after finished word");

  // the winning stream still holds its head when emitted, and loses it after
  a_winner_head: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |-> present_vec[best_idx_r] ##1 !present_vec[$past(best_idx_r)])
    else $error("emitted stream head missing or not cleared");

endmodule

/* rtl/core/kms_cell.sv */
// one stream cell: holds a head, its flags, and one stage of the min scan
module kms_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  kms_pkg::wr_t  wr,
  input  kms_pkg::clr_t clr_sel,
  input  logic          clr_all,
  input  logic          used,
  input  kms_pkg::cand_t cand_in,
  output kms_pkg::cand_t cand_out,
  output logic          present,
  output logic          done
);
  import kms_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [VAL_W-1:0] head_r;
  logic                    present_r, present_nxt;
  logic                    done_r, done_nxt;
  cand_t                   cand_r, cand_nxt;
  logic                    wr_hit;
  logic                    take;

  assign wr_hit = wr.en && (wr.idx == MY_IDX);

  always_comb begin
    present_nxt = present_r;
    done_nxt    = done_r;
    if (clr_all) begin
      present_nxt = 1'b0;
      done_nxt    = 1'b0;
    end else if (wr_hit) begin
      present_nxt = wr.has;
      done_nxt    = !wr.has;
    end else if (clr_sel.en && (clr_sel.idx == MY_IDX)) begin
      present_nxt = 1'b0;
    end
  end

  // strict less-than keeps ties on the lower index
  assign take = cand_in.tok && present_r && used &&
                (!cand_in.found || (head_r < cand_in.val));

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.val   = head_r;
      cand_nxt.idx   = MY_IDX;
    end
  end

  // only the token bit of the candidate needs a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= 1'b0;
      done_r     <= 1'b0;
      cand_r.tok <= 1'b0;
    end else begin
      present_r  <= present_nxt;
      done_r     <= done_nxt;
      cand_r     <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit && wr.has) begin
      head_r <= wr.val;
    end
  end

  assign cand_out = cand_r;
  assign present  = present_r;
  assign done     = done_r;

endmodule
